/* design/trjs_pkg.sv */
// Package for the tracker row jump scanner: parse state, result word and codes.
// Used by the interfaces, the step logic and the top level.
package trjs_pkg;

  localparam int unsigned CHANNELS = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ROW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_OFF    = 2'd1;

  localparam logic [1:0] PH_MASK = 2'd0;
  localparam logic [1:0] PH_SKIP = 2'd1;
  localparam logic [1:0] PH_CMD  = 2'd2;
  localparam logic [1:0] PH_INFO = 2'd3;

  localparam logic [7:0] MASK_TWO  = 8'h20;
  localparam logic [7:0] MASK_ONE  = 8'h40;
  localparam logic [7:0] MASK_FX   = 8'h80;
  localparam logic [7:0] CHAN_BITS = 8'h1F;
  localparam logic [7:0] CMD_JUMP  = 8'h02;
  localparam logic [7:0] CMD_BREAK = 8'h03;

  typedef struct packed {
    logic [1:0] phase;
    logic [5:0] rows_left;
    logic [2:0] skip_left;
    logic [7:0] entry_mask;
    logic       entry_on;
    logic [7:0] held_command;
    logic       jump_seen;
    logic [7:0] jump_value;
    logic       break_seen;
    logic [7:0] break_value;
    logic       answered;
  } state_t;

  typedef struct packed {
    logic       jump_found;
    logic [7:0] jump_order;
    logic       break_found;
    logic [7:0] break_row;
    logic       ran_out;
  } result_t;

  function automatic state_t restart_state(logic [5:0] row);
    state_t s;
    s = '0;
    s.phase = PH_MASK;
    s.rows_left = row;
    return s;
  endfunction

endpackage

/* design/trjs_if.sv */
// Channel interfaces for the tracker row jump scanner: byte in, result out, config.
// Depends on trjs_pkg for widths.
interface trjs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pattern_byte;
  logic       last_byte;
  modport source (output valid, output pattern_byte, output last_byte, input ready);
  modport sink   (input valid, input pattern_byte, input last_byte, output ready);
endinterface

interface trjs_out_if;
  logic       valid;
  logic       ready;
  logic       jump_found;
  logic [7:0] jump_order;
  logic       break_found;
  logic [7:0] break_row;
  logic       ran_out;
  modport source (output valid, output jump_found, output jump_order, output break_found,
                  output break_row, output ran_out, input ready);
  modport sink   (input valid, input jump_found, input jump_order, input break_found,
                  input break_row, input ran_out, output ready);
endinterface

interface trjs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [trjs_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/tracker_row_jump_scanner.sv */
// Top level of the tracker row jump scanner: input register, parse state, result register.
// Depends on trjs_pkg, the channel interfaces and trjs_step.
//
//   channel  dir  handshake     word
//   in_if    in   valid/ready   pattern_byte, last_byte
//   out_if   out  valid/ready   jump_found, jump_order, break_found, break_row, ran_out
//   cfg_if   in   valid/ready   index, data (always ready)
//
// One word per cycle unless stalled; a result is registered when its word advances.
// The input register's word is parsed combinationally against the parse state register.
// A held result stalls the input register only when its word yields another result.
// rst_n (synchronous) clears the parse state, both registers and the config.
module tracker_row_jump_scanner (
  input logic clk,
  input logic rst_n,
  trjs_in_if.sink    in_if,
  trjs_out_if.source out_if,
  trjs_cfg_if.sink   cfg_if
);
  import trjs_pkg::*;

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_last_r;
  state_t            state_r;
  state_t            state_nxt;
  state_t            step_state;
  logic [5:0]        target_row_r;
  logic [31:0]       chan_off_r;
  logic              out_valid_r;
  result_t           out_res_r;
  logic              step_emit;
  result_t           step_res;
  logic              advance;
  logic              in_take;
  logic              cfg_take;

  trjs_step u_step (
    .cur        (state_r),
    .pat_byte   (s1_byte_r),
    .last       (s1_last_r),
    .target_row (target_row_r),
    .chan_off   (chan_off_r),
    .nxt        (step_state),
    .emit       (step_emit),
    .res        (step_res)
  );

  assign advance     = s1_valid_r && (!step_emit || !out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;
  assign in_take     = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_take    = cfg_if.valid;

  // a target row write also reloads the row count
  always_comb begin
    state_nxt = advance ? step_state : state_r;
    if (cfg_take && cfg_if.index == REG_TARGET_ROW) begin
      state_nxt.rows_left = cfg_if.data[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      target_row_r <= '0;
      chan_off_r   <= '0;
      state_r      <= restart_state(6'd0);
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
        s1_byte_r  <= in_if.pattern_byte;
        s1_last_r  <= in_if.last_byte;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end

      if (advance && step_emit) begin
        out_valid_r <= 1'b1;
        out_res_r   <= step_res;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      state_r <= state_nxt;

      if (cfg_take && cfg_if.index == REG_TARGET_ROW) begin
        target_row_r <= cfg_if.data[5:0];
      end
      if (cfg_take && cfg_if.index == REG_CHAN_OFF) begin
        chan_off_r <= cfg_if.data;
      end
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.jump_found  = out_res_r.jump_found;
  assign out_if.jump_order  = out_res_r.jump_order;
  assign out_if.break_found = out_res_r.break_found;
  assign out_if.break_row   = out_res_r.break_row;
  assign out_if.ran_out     = out_res_r.ran_out;

endmodule

/* design/trjs_step.sv */
// Per-word parse step: next parse state and optional result for one pattern byte.
// Depends on trjs_pkg.
module trjs_step (
  input  trjs_pkg::state_t  cur,
  input  logic [7:0]        pat_byte,
  input  logic              last,
  input  logic [5:0]        target_row,
  input  logic [31:0]       chan_off,
  output trjs_pkg::state_t  nxt,
  output logic              emit,
  output trjs_pkg::result_t res
);
  import trjs_pkg::*;

  logic [2:0] pre_cnt;
  logic [2:0] all_cnt;
  logic [2:0] skip_dec;
  logic [4:0] chan;
  logic       chan_is_off;
  logic       found;

  assign pre_cnt  = ((pat_byte & MASK_TWO) != 8'd0 ? 3'd2 : 3'd0) +
                    ((pat_byte & MASK_ONE) != 8'd0 ? 3'd1 : 3'd0);
  assign all_cnt  = pre_cnt + ((pat_byte & MASK_FX) != 8'd0 ? 3'd2 : 3'd0);
  assign skip_dec = cur.skip_left - ((cur.skip_left != 3'd0) ? 3'd1 : 3'd0);
  assign chan     = 5'(pat_byte & CHAN_BITS);
  assign chan_is_off = (32'(chan) < CHANNELS) && chan_off[chan];

  always_comb begin
    nxt   = cur;
    found = 1'b0;
    emit  = 1'b0;
    res   = '0;
    if (!cur.answered) begin
      case (cur.phase)
        PH_MASK: begin
          nxt.entry_mask = pat_byte;
          if (cur.rows_left != 6'd0) begin
            if (pat_byte == 8'd0) begin
              nxt.rows_left = cur.rows_left - 6'd1;
            end else begin
              nxt.entry_on  = 1'b0;
              nxt.skip_left = all_cnt;
              nxt.phase     = (all_cnt != 3'd0) ? PH_SKIP : PH_MASK;
            end
          end else if (pat_byte == 8'd0) begin
            found = 1'b1;
          end else if (chan_is_off) begin
            nxt.entry_on  = 1'b0;
            nxt.skip_left = all_cnt;
            nxt.phase     = (all_cnt != 3'd0) ? PH_SKIP : PH_MASK;
          end else begin
            nxt.entry_on  = 1'b1;
            nxt.skip_left = pre_cnt;
            if (pre_cnt != 3'd0) nxt.phase = PH_SKIP;
            else if ((pat_byte & MASK_FX) != 8'd0) nxt.phase = PH_CMD;
            else nxt.phase = PH_MASK;
          end
        end
        PH_SKIP: begin
          nxt.skip_left = skip_dec;
          if (skip_dec == 3'd0) begin
            nxt.phase = (cur.entry_on && (cur.entry_mask & MASK_FX) != 8'd0) ? PH_CMD : PH_MASK;
          end
        end
        PH_CMD: begin
          nxt.held_command = pat_byte;
          nxt.phase        = PH_INFO;
        end
        default: begin
          if (cur.held_command == CMD_JUMP) begin
            nxt.jump_seen  = 1'b1;
            nxt.jump_value = pat_byte;
          end else if (cur.held_command == CMD_BREAK) begin
            nxt.break_seen  = 1'b1;
            nxt.break_value = pat_byte;
          end
          nxt.phase = PH_MASK;
          found = nxt.jump_seen && nxt.break_seen;
        end
      endcase
    end

    if (found) begin
      emit            = 1'b1;
      res.jump_found  = nxt.jump_seen;
      res.jump_order  = nxt.jump_seen ? nxt.jump_value : 8'd0;
      res.break_found = nxt.break_seen;
      res.break_row   = nxt.break_seen ? nxt.break_value : 8'd0;
      res.ran_out     = 1'b0;
      nxt.answered    = 1'b1;
    end

    if (last) begin
      if (!nxt.answered) begin
        emit        = 1'b1;
        res         = '0;
        res.ran_out = 1'b1;
      end
      nxt = restart_state(target_row);
    end
  end

endmodule

/* design/trjs_checker.sv */
// Port-level checker for the tracker row jump scanner, bound to the top level.
// Depends on the top level's channel interfaces.
module trjs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       jump_found,
  input logic [7:0] jump_order,
  input logic       break_found,
  input logic [7:0] break_row,
  input logic       ran_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(jump_order) && $stable(break_row)
      && $stable(ran_out) && $stable(jump_found) && $stable(break_found))
    else $error("result word changed while stalled");

  a_ran_out_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ran_out |-> !jump_found && !break_found
      && jump_order == 8'd0 && break_row == 8'd0)
    else $error("ran_out word carries found data");

  a_unfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (jump_found || jump_order == 8'd0) && (break_found || break_row == 8'd0))
    else $error("value set without its found flag");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind tracker_row_jump_scanner trjs_checker u_trjs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .jump_found  (out_if.jump_found),
  .jump_order  (out_if.jump_order),
  .break_found (out_if.break_found),
  .break_row   (out_if.break_row),
  .ran_out     (out_if.ran_out)
);
